/* rtl/c8cpu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types, opcode codes, font glyphs and digit helpers for the CHIP-8 core.
// No dependencies.
package c8cpu_pkg;

	localparam logic [11:0] PROG_START = 12'h200;
	localparam logic [11:0] FONT_START = 12'h050;
	localparam logic [11:0] FONT_END   = 12'h0A0;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [3:0] N_MOV  = 4'h0;
	localparam logic [3:0] N_OR   = 4'h1;
	localparam logic [3:0] N_AND  = 4'h2;
	localparam logic [3:0] N_XOR  = 4'h3;
	localparam logic [3:0] N_ADD  = 4'h4;
	localparam logic [3:0] N_SUB  = 4'h5;
	localparam logic [3:0] N_SHR  = 4'h6;
	localparam logic [3:0] N_SUBN = 4'h7;
	localparam logic [3:0] N_SHL  = 4'hE;

	localparam logic [7:0] EX_SKP  = 8'h9E;
	localparam logic [7:0] EX_SKNP = 8'hA1;

	localparam logic [7:0] FX_GET_DELAY = 8'h07;
	localparam logic [7:0] FX_WAIT_KEY  = 8'h0A;
	localparam logic [7:0] FX_SET_DELAY = 8'h15;
	localparam logic [7:0] FX_SET_SOUND = 8'h18;
	localparam logic [7:0] FX_ADD_I     = 8'h1E;
	localparam logic [7:0] FX_FONT      = 8'h29;
	localparam logic [7:0] FX_BCD       = 8'h33;
	localparam logic [7:0] FX_STORE     = 8'h55;
	localparam logic [7:0] FX_LOAD      = 8'h65;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_KEY   = 2'd1,
		KIND_EXEC  = 2'd2,
		KIND_PIXEL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_UNKNOWN   = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		GRP_SYS     = 4'h0,
		GRP_JP      = 4'h1,
		GRP_CALL    = 4'h2,
		GRP_SE_IMM  = 4'h3,
		GRP_SNE_IMM = 4'h4,
		GRP_SE_REG  = 4'h5,
		GRP_LD_IMM  = 4'h6,
		GRP_ADD_IMM = 4'h7,
		GRP_ALU     = 4'h8,
		GRP_SNE_REG = 4'h9,
		GRP_LD_I    = 4'hA,
		GRP_JP_V0   = 4'hB,
		GRP_RND     = 4'hC,
		GRP_DRW     = 4'hD,
		GRP_SKP     = 4'hE,
		GRP_MISC    = 4'hF
	} group_t;

	typedef enum logic [3:0] {
		ALU_MOV,
		ALU_OR,
		ALU_AND,
		ALU_XOR,
		ALU_ADD,
		ALU_SUB,
		ALU_SUBN,
		ALU_SHR,
		ALU_SHL
	} alu_op_t;

	typedef struct packed {
		logic [7:0] res;
		logic       flag;
		logic       eq;
	} alu_out_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_PIX,
		S_FETCH_HI,
		S_FETCH_LO,
		S_READ_X,
		S_READ_Y,
		S_DECODE,
		S_RET,
		S_JUMP_V0,
		S_CLS,
		S_DRAW_FETCH,
		S_DRAW_MASK,
		S_DRAW_ROW_A,
		S_DRAW_ROW_B,
		S_WRITE_VF,
		S_BCD_TENS,
		S_BCD_HUND,
		S_STORE_RD,
		S_STORE_WR,
		S_LOAD_RD,
		S_LOAD_WR,
		S_TICK
	} state_t;

	localparam logic [7:0] FONT_GLYPHS [80] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	function automatic logic [7:0] font_byte(input logic [6:0] idx);
		return (idx < 7'd80) ? FONT_GLYPHS[idx] : 8'h00;
	endfunction

	// {hundreds, tens, ones}; reciprocal multiplies are exact over 0..255
	function automatic logic [11:0] bcd_digits(input logic [7:0] v);
		logic [13:0] hp;
		logic [1:0]  h;
		logic [7:0]  r8;
		logic [14:0] tp;
		logic [3:0]  t;
		logic [6:0]  o;
		hp = {6'b0, v} * 14'd41;
		h  = hp[13:12];
		r8 = v - ({6'b0, h} * 8'd100);
		tp = {8'b0, r8[6:0]} * 15'd205;
		t  = tp[14:11];
		o  = r8[6:0] - ({3'b0, t} * 7'd10);
		return {2'b00, h, t, o[3:0]};
	endfunction

endpackage
`default_nettype wire

/* rtl/c8cpu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module c8cpu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/c8cpu_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared 8-bit ALU for register ops, immediate add and skip compares.
// Depends on c8cpu_pkg.
module c8cpu_alu (
	input  wire c8cpu_pkg::alu_op_t  op,
	input  wire logic [7:0]          a,
	input  wire logic [7:0]          b,
	output c8cpu_pkg::alu_out_t      result
);

	logic [8:0] sum;

	always_comb begin
		sum = {1'b0, a} + {1'b0, b};
		result.res  = b;
		result.flag = 1'b0;
		result.eq   = (a == b);
		unique case (op)
			c8cpu_pkg::ALU_MOV: begin
				result.res = b;
			end
			c8cpu_pkg::ALU_OR: begin
				result.res = a | b;
			end
			c8cpu_pkg::ALU_AND: begin
				result.res = a & b;
			end
			c8cpu_pkg::ALU_XOR: begin
				result.res = a ^ b;
			end
			c8cpu_pkg::ALU_ADD: begin
				result.res  = sum[7:0];
				result.flag = sum[8];
			end
			c8cpu_pkg::ALU_SUB: begin
				result.res  = a - b;
				result.flag = (a > b);
			end
			c8cpu_pkg::ALU_SUBN: begin
				result.res  = b - a;
				result.flag = (b > a);
			end
			c8cpu_pkg::ALU_SHR: begin
				result.res  = {1'b0, a[7:1]};
				result.flag = a[0];
			end
			c8cpu_pkg::ALU_SHL: begin
				result.res  = {a[6:0], 1'b0};
				result.flag = a[7];
			end
			default: begin
				result.res = b;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/chip8_cpu_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// CHIP-8 core: sequencer over one memory port, one register-file port and a shared ALU.
// Load/key transactions: result in the cycle after accept; pixel read: via S_PIX.
// Execute: fetch, read Vx/Vy, decode, tick; clear screen walks 32 rows; draw walks n rows;
// Fx55/Fx65 walk V0..Vx. One transaction at a time; busy high until the unstallable strobe.
// Reset: clearing pass (memory, font, screen, registers) with busy high.
// Depends on c8cpu_pkg, c8cpu_ram, c8cpu_alu.
module chip8_cpu_core #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [11:0] load_offset,
	input  wire logic [7:0]  load_byte,
	input  wire logic [3:0]  key_number,
	input  wire logic        key_down,
	input  wire logic [7:0]  random_byte,
	input  wire logic [10:0] pixel_address,
	output logic             done,
	output logic             draw_flag,
	output logic             beep_flag,
	output logic             pixel_on,
	output logic [1:0]       status,
	output logic [11:0]      program_counter
);

	localparam int unsigned SAW = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

	c8cpu_pkg::state_t  state_q, state_d;
	c8cpu_pkg::status_t hcode_q, hcode_d;
	logic [11:0] cnt_q, cnt_d;
	logic [11:0] pc_q, pc_d;
	logic [11:0] next_q, next_d;
	logic [15:0] i_q, i_d;
	logic [SPW-1:0] sp_q, sp_d;
	logic [7:0]  dt_q, dt_d;
	logic [7:0]  snd_q, snd_d;
	logic [15:0] keys_q, keys_d;
	logic        prog_q, prog_d;
	logic        halt_q, halt_d;
	logic        flag_q, flag_d;
	logic        draw_q, draw_d;
	logic        unk_q, unk_d;
	logic [15:0] op_q, op_d;
	logic [7:0]  a_q, a_d;
	logic [7:0]  b_q, b_d;
	logic [7:0]  rand_q, rand_d;
	logic [5:0]  col_q, col_d;
	logic [5:0]  row_q, row_d;
	logic [71:0] mask_q, mask_d;

	logic        done_q;
	logic        out_draw_q;
	logic        out_beep_q;
	logic        out_pix_q;
	c8cpu_pkg::status_t out_status_q;
	logic [11:0] out_pc_q;

	logic        fin;
	logic        fin_draw;
	logic        fin_beep;
	logic        fin_pix;
	c8cpu_pkg::status_t fin_status;
	logic [11:0] fin_pc;

	logic        mem_we;
	logic [11:0] mem_waddr, mem_raddr;
	logic [7:0]  mem_wdata, mem_rdata;
	logic        fb_we;
	logic [4:0]  fb_waddr, fb_raddr;
	logic [63:0] fb_wdata, fb_rdata;
	logic        v_we;
	logic [3:0]  v_waddr, v_raddr;
	logic [7:0]  v_wdata, v_rdata;
	logic        stk_we;
	logic [SAW-1:0] stk_waddr, stk_raddr;
	logic [11:0] stk_wdata, stk_rdata;

	c8cpu_pkg::alu_op_t  alu_op;
	logic [7:0]          alu_b;
	c8cpu_pkg::alu_out_t alu_res;
	logic                alu_ok;
	logic                alu_vf;

	c8cpu_pkg::group_t grp;
	logic [3:0]  x;
	logic [7:0]  nn;
	logic [11:0] nnn;
	logic [3:0]  key_first;
	logic [7:0]  sprite_rev;
	logic [11:0] digits;
	logic [16:0] i_sum;
	logic [SPW-1:0] sp_m1;
	logic [11:0] i_cnt;

	c8cpu_ram #(.WIDTH(8), .DEPTH(4096)) u_main_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	c8cpu_ram #(.WIDTH(64), .DEPTH(32)) u_frame (
		.clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
		.raddr(fb_raddr), .rdata(fb_rdata)
	);

	c8cpu_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	c8cpu_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	c8cpu_alu u_alu (
		.op(alu_op), .a(a_q), .b(alu_b), .result(alu_res)
	);

	// opcode fields and ALU operand select
	always_comb begin
		grp    = c8cpu_pkg::group_t'(op_q[15:12]);
		x      = op_q[11:8];
		nn     = op_q[7:0];
		nnn    = op_q[11:0];
		alu_b  = b_q;
		alu_op = c8cpu_pkg::ALU_ADD;
		alu_ok = 1'b1;
		alu_vf = 1'b0;
		if (grp == c8cpu_pkg::GRP_SE_IMM || grp == c8cpu_pkg::GRP_SNE_IMM ||
				grp == c8cpu_pkg::GRP_ADD_IMM) begin
			alu_b = nn;
		end
		if (grp == c8cpu_pkg::GRP_ALU) begin
			case (op_q[3:0])
				c8cpu_pkg::N_MOV:  alu_op = c8cpu_pkg::ALU_MOV;
				c8cpu_pkg::N_OR:   alu_op = c8cpu_pkg::ALU_OR;
				c8cpu_pkg::N_AND:  alu_op = c8cpu_pkg::ALU_AND;
				c8cpu_pkg::N_XOR:  alu_op = c8cpu_pkg::ALU_XOR;
				c8cpu_pkg::N_ADD: begin
					alu_op = c8cpu_pkg::ALU_ADD;
					alu_vf = 1'b1;
				end
				c8cpu_pkg::N_SUB: begin
					alu_op = c8cpu_pkg::ALU_SUB;
					alu_vf = 1'b1;
				end
				c8cpu_pkg::N_SHR: begin
					alu_op = c8cpu_pkg::ALU_SHR;
					alu_vf = 1'b1;
				end
				c8cpu_pkg::N_SUBN: begin
					alu_op = c8cpu_pkg::ALU_SUBN;
					alu_vf = 1'b1;
				end
				c8cpu_pkg::N_SHL: begin
					alu_op = c8cpu_pkg::ALU_SHL;
					alu_vf = 1'b1;
				end
				default: alu_ok = 1'b0;
			endcase
		end
	end

	// lowest pressed key wins for Fx0A
	always_comb begin
		key_first = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k]) begin
				key_first = 4'(k);
			end
		end
		for (int k = 0; k < 8; k++) begin
			sprite_rev[k] = mem_rdata[7 - k];
		end
	end

	assign digits = c8cpu_pkg::bcd_digits(a_q);
	assign i_sum  = {1'b0, i_q} + {9'b0, a_q};
	assign sp_m1  = sp_q - 1'b1;
	assign i_cnt  = i_q[11:0] + cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= c8cpu_pkg::S_CLEAR;
			hcode_q      <= c8cpu_pkg::STAT_OK;
			cnt_q        <= '0;
			pc_q         <= c8cpu_pkg::PROG_START;
			next_q       <= '0;
			i_q          <= '0;
			sp_q         <= '0;
			dt_q         <= '0;
			snd_q        <= '0;
			keys_q       <= '0;
			prog_q       <= 1'b0;
			halt_q       <= 1'b0;
			flag_q       <= 1'b0;
			draw_q       <= 1'b0;
			unk_q        <= 1'b0;
			done_q       <= 1'b0;
			out_draw_q   <= 1'b0;
			out_beep_q   <= 1'b0;
			out_pix_q    <= 1'b0;
			out_status_q <= c8cpu_pkg::STAT_OK;
			out_pc_q     <= '0;
		end else begin
			state_q <= state_d;
			hcode_q <= hcode_d;
			cnt_q   <= cnt_d;
			pc_q    <= pc_d;
			next_q  <= next_d;
			i_q     <= i_d;
			sp_q    <= sp_d;
			dt_q    <= dt_d;
			snd_q   <= snd_d;
			keys_q  <= keys_d;
			prog_q  <= prog_d;
			halt_q  <= halt_d;
			flag_q  <= flag_d;
			draw_q  <= draw_d;
			unk_q   <= unk_d;
			done_q  <= fin;
			if (fin) begin
				out_draw_q   <= fin_draw;
				out_beep_q   <= fin_beep;
				out_pix_q    <= fin_pix;
				out_status_q <= fin_status;
				out_pc_q     <= fin_pc;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		a_q    <= a_d;
		b_q    <= b_d;
		rand_q <= rand_d;
		col_q  <= col_d;
		row_q  <= row_d;
		mask_q <= mask_d;
	end

	always_comb begin
		state_d = state_q;
		hcode_d = hcode_q;
		cnt_d   = cnt_q;
		pc_d    = pc_q;
		next_d  = next_q;
		i_d     = i_q;
		sp_d    = sp_q;
		dt_d    = dt_q;
		snd_d   = snd_q;
		keys_d  = keys_q;
		prog_d  = prog_q;
		halt_d  = halt_q;
		flag_d  = flag_q;
		draw_d  = draw_q;
		unk_d   = unk_q;
		op_d    = op_q;
		a_d     = a_q;
		b_d     = b_q;
		rand_d  = rand_q;
		col_d   = col_q;
		row_d   = row_q;
		mask_d  = mask_q;

		fin        = 1'b0;
		fin_draw   = 1'b0;
		fin_beep   = 1'b0;
		fin_pix    = 1'b0;
		fin_status = halt_q ? hcode_q : c8cpu_pkg::STAT_OK;
		fin_pc     = pc_q;

		mem_we    = 1'b0;
		mem_waddr = i_cnt;
		mem_wdata = v_rdata;
		mem_raddr = i_cnt;
		fb_we     = 1'b0;
		fb_waddr  = row_q[4:0];
		fb_wdata  = fb_rdata ^ mask_q[63:0];
		fb_raddr  = row_q[4:0];
		v_we      = 1'b0;
		v_waddr   = x;
		v_wdata   = alu_res.res;
		v_raddr   = '0;
		stk_we    = 1'b0;
		stk_waddr = sp_q[SAW-1:0];
		stk_wdata = pc_q;
		stk_raddr = sp_m1[SAW-1:0];

		unique case (state_q)
			c8cpu_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = (cnt_q >= c8cpu_pkg::FONT_START && cnt_q < c8cpu_pkg::FONT_END) ?
					c8cpu_pkg::font_byte(7'(cnt_q - c8cpu_pkg::FONT_START)) : 8'h00;
				fb_we    = (cnt_q[11:5] == '0);
				fb_waddr = cnt_q[4:0];
				fb_wdata = '0;
				v_we     = (cnt_q[11:4] == '0);
				v_waddr  = cnt_q[3:0];
				v_wdata  = '0;
				cnt_d    = cnt_q + 12'd1;
				if (cnt_q == 12'hFFF) begin
					state_d = c8cpu_pkg::S_IDLE;
				end
			end
			c8cpu_pkg::S_IDLE: begin
				mem_raddr = pc_q;
				fb_raddr  = pixel_address[10:6];
				if (start) begin
					rand_d = random_byte;
					col_d  = pixel_address[5:0];
					unique case (c8cpu_pkg::kind_t'(kind))
						c8cpu_pkg::KIND_LOAD: begin
							mem_we    = 1'b1;
							mem_waddr = c8cpu_pkg::PROG_START + load_offset;
							mem_wdata = load_byte;
							prog_d    = 1'b1;
							fin       = 1'b1;
						end
						c8cpu_pkg::KIND_KEY: begin
							keys_d[key_number] = key_down;
							fin = 1'b1;
						end
						c8cpu_pkg::KIND_EXEC: begin
							if (prog_q && !halt_q) begin
								draw_d  = 1'b0;
								unk_d   = 1'b0;
								state_d = c8cpu_pkg::S_FETCH_HI;
							end else begin
								fin = 1'b1;
							end
						end
						c8cpu_pkg::KIND_PIXEL: begin
							state_d = c8cpu_pkg::S_PIX;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			c8cpu_pkg::S_PIX: begin
				fin     = 1'b1;
				fin_pix = fb_rdata[col_q];
				state_d = c8cpu_pkg::S_IDLE;
			end
			c8cpu_pkg::S_FETCH_HI: begin
				op_d[15:8] = mem_rdata;
				mem_raddr  = pc_q + 12'd1;
				state_d    = c8cpu_pkg::S_FETCH_LO;
			end
			c8cpu_pkg::S_FETCH_LO: begin
				op_d[7:0] = mem_rdata;
				v_raddr   = op_q[11:8];
				state_d   = c8cpu_pkg::S_READ_X;
			end
			c8cpu_pkg::S_READ_X: begin
				a_d     = v_rdata;
				v_raddr = op_q[7:4];
				state_d = c8cpu_pkg::S_READ_Y;
			end
			c8cpu_pkg::S_READ_Y: begin
				b_d     = v_rdata;
				state_d = c8cpu_pkg::S_DECODE;
			end
			c8cpu_pkg::S_DECODE: begin
				next_d  = pc_q + 12'd2;
				state_d = c8cpu_pkg::S_TICK;
				unique case (grp)
					c8cpu_pkg::GRP_SYS: begin
						if (op_q == c8cpu_pkg::OP_CLS) begin
							cnt_d   = '0;
							draw_d  = 1'b1;
							state_d = c8cpu_pkg::S_CLS;
						end else if (op_q == c8cpu_pkg::OP_RET) begin
							if (sp_q == '0) begin
								halt_d     = 1'b1;
								hcode_d    = c8cpu_pkg::STAT_UNDERFLOW;
								fin        = 1'b1;
								fin_status = c8cpu_pkg::STAT_UNDERFLOW;
								state_d    = c8cpu_pkg::S_IDLE;
							end else begin
								state_d = c8cpu_pkg::S_RET;
							end
						end else begin
							unk_d = 1'b1;
						end
					end
					c8cpu_pkg::GRP_JP: begin
						next_d = nnn;
					end
					c8cpu_pkg::GRP_CALL: begin
						if (sp_q >= SPW'(STACK_DEPTH)) begin
							halt_d     = 1'b1;
							hcode_d    = c8cpu_pkg::STAT_OVERFLOW;
							fin        = 1'b1;
							fin_status = c8cpu_pkg::STAT_OVERFLOW;
							state_d    = c8cpu_pkg::S_IDLE;
						end else begin
							stk_we = 1'b1;
							sp_d   = sp_q + 1'b1;
							next_d = nnn;
						end
					end
					c8cpu_pkg::GRP_SE_IMM, c8cpu_pkg::GRP_SE_REG: begin
						if (alu_res.eq) begin
							next_d = pc_q + 12'd4;
						end
					end
					c8cpu_pkg::GRP_SNE_IMM, c8cpu_pkg::GRP_SNE_REG: begin
						if (!alu_res.eq) begin
							next_d = pc_q + 12'd4;
						end
					end
					c8cpu_pkg::GRP_LD_IMM: begin
						v_we    = 1'b1;
						v_wdata = nn;
					end
					c8cpu_pkg::GRP_ADD_IMM: begin
						v_we = 1'b1;
					end
					c8cpu_pkg::GRP_ALU: begin
						if (alu_ok) begin
							v_we = 1'b1;
							if (alu_vf) begin
								flag_d  = alu_res.flag;
								state_d = c8cpu_pkg::S_WRITE_VF;
							end
						end else begin
							unk_d = 1'b1;
						end
					end
					c8cpu_pkg::GRP_LD_I: begin
						i_d = {4'b0, nnn};
					end
					c8cpu_pkg::GRP_JP_V0: begin
						state_d = c8cpu_pkg::S_JUMP_V0;
					end
					c8cpu_pkg::GRP_RND: begin
						v_we    = 1'b1;
						v_wdata = rand_q & nn;
					end
					c8cpu_pkg::GRP_DRW: begin
						flag_d  = 1'b0;
						cnt_d   = '0;
						draw_d  = 1'b1;
						state_d = c8cpu_pkg::S_DRAW_FETCH;
					end
					c8cpu_pkg::GRP_SKP: begin
						if (nn == c8cpu_pkg::EX_SKP) begin
							if (keys_q[a_q[3:0]]) begin
								next_d = pc_q + 12'd4;
							end
						end else if (nn == c8cpu_pkg::EX_SKNP) begin
							if (!keys_q[a_q[3:0]]) begin
								next_d = pc_q + 12'd4;
							end
						end else begin
							unk_d = 1'b1;
						end
					end
					c8cpu_pkg::GRP_MISC: begin
						case (nn)
							c8cpu_pkg::FX_GET_DELAY: begin
								v_we    = 1'b1;
								v_wdata = dt_q;
							end
							c8cpu_pkg::FX_SET_DELAY: dt_d = a_q;
							c8cpu_pkg::FX_SET_SOUND: snd_d = a_q;
							c8cpu_pkg::FX_ADD_I: begin
								i_d = i_sum[15:0];
								if (i_sum > 17'h00FFF) begin
									flag_d  = 1'b1;
									state_d = c8cpu_pkg::S_WRITE_VF;
								end
							end
							c8cpu_pkg::FX_WAIT_KEY: begin
								if (|keys_q) begin
									v_we    = 1'b1;
									v_wdata = {4'b0, key_first};
								end else begin
									next_d = pc_q;
								end
							end
							c8cpu_pkg::FX_FONT: begin
								i_d = {4'b0, c8cpu_pkg::FONT_START} + {6'b0, a_q, 2'b0} +
									{8'b0, a_q};
							end
							c8cpu_pkg::FX_BCD: begin
								mem_we    = 1'b1;
								mem_waddr = i_q[11:0] + 12'd2;
								mem_wdata = {4'b0, digits[3:0]};
								state_d   = c8cpu_pkg::S_BCD_TENS;
							end
							c8cpu_pkg::FX_STORE: begin
								cnt_d   = '0;
								state_d = c8cpu_pkg::S_STORE_RD;
							end
							c8cpu_pkg::FX_LOAD: begin
								cnt_d   = '0;
								state_d = c8cpu_pkg::S_LOAD_RD;
							end
							default: unk_d = 1'b1;
						endcase
					end
					default: unk_d = 1'b1;
				endcase
			end
			c8cpu_pkg::S_RET: begin
				next_d  = stk_rdata + 12'd2;
				sp_d    = sp_m1;
				state_d = c8cpu_pkg::S_TICK;
			end
			c8cpu_pkg::S_JUMP_V0: begin
				next_d  = nnn + {4'b0, v_rdata};
				state_d = c8cpu_pkg::S_TICK;
			end
			c8cpu_pkg::S_CLS: begin
				fb_we    = 1'b1;
				fb_waddr = cnt_q[4:0];
				fb_wdata = '0;
				cnt_d    = cnt_q + 12'd1;
				if (cnt_q[4:0] == 5'd31) begin
					state_d = c8cpu_pkg::S_TICK;
				end
			end
			c8cpu_pkg::S_DRAW_FETCH: begin
				if (cnt_q[3:0] == op_q[3:0]) begin
					state_d = c8cpu_pkg::S_WRITE_VF;
				end else begin
					state_d = c8cpu_pkg::S_DRAW_MASK;
				end
			end
			c8cpu_pkg::S_DRAW_MASK: begin
				// sprite bit i lands on column x+i; the top byte spills into the next row
				mask_d   = {64'b0, sprite_rev} << a_q[5:0];
				row_d    = {1'b0, b_q[4:0]} + {2'b0, cnt_q[3:0]};
				fb_raddr = row_d[4:0];
				if (row_d[5]) begin
					cnt_d   = cnt_q + 12'd1;
					state_d = c8cpu_pkg::S_DRAW_FETCH;
				end else begin
					state_d = c8cpu_pkg::S_DRAW_ROW_A;
				end
			end
			c8cpu_pkg::S_DRAW_ROW_A: begin
				fb_we    = 1'b1;
				fb_wdata = fb_rdata ^ mask_q[63:0];
				flag_d   = flag_q | (|(fb_rdata & mask_q[63:0]));
				fb_raddr = row_q[4:0] + 5'd1;
				if ((|mask_q[71:64]) && row_q[4:0] != 5'd31) begin
					state_d = c8cpu_pkg::S_DRAW_ROW_B;
				end else begin
					cnt_d   = cnt_q + 12'd1;
					state_d = c8cpu_pkg::S_DRAW_FETCH;
				end
			end
			c8cpu_pkg::S_DRAW_ROW_B: begin
				fb_we    = 1'b1;
				fb_waddr = row_q[4:0] + 5'd1;
				fb_wdata = fb_rdata ^ {56'b0, mask_q[71:64]};
				flag_d   = flag_q | (|(fb_rdata[7:0] & mask_q[71:64]));
				cnt_d    = cnt_q + 12'd1;
				state_d  = c8cpu_pkg::S_DRAW_FETCH;
			end
			c8cpu_pkg::S_WRITE_VF: begin
				v_we    = 1'b1;
				v_waddr = 4'hF;
				v_wdata = {7'b0, flag_q};
				state_d = c8cpu_pkg::S_TICK;
			end
			c8cpu_pkg::S_BCD_TENS: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[11:0] + 12'd1;
				mem_wdata = {4'b0, digits[7:4]};
				state_d   = c8cpu_pkg::S_BCD_HUND;
			end
			c8cpu_pkg::S_BCD_HUND: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[11:0];
				mem_wdata = {4'b0, digits[11:8]};
				state_d   = c8cpu_pkg::S_TICK;
			end
			c8cpu_pkg::S_STORE_RD: begin
				v_raddr = cnt_q[3:0];
				state_d = c8cpu_pkg::S_STORE_WR;
			end
			c8cpu_pkg::S_STORE_WR: begin
				mem_we = 1'b1;
				cnt_d  = cnt_q + 12'd1;
				if (cnt_q[3:0] == x) begin
					state_d = c8cpu_pkg::S_TICK;
				end else begin
					state_d = c8cpu_pkg::S_STORE_RD;
				end
			end
			c8cpu_pkg::S_LOAD_RD: begin
				state_d = c8cpu_pkg::S_LOAD_WR;
			end
			c8cpu_pkg::S_LOAD_WR: begin
				v_we    = 1'b1;
				v_waddr = cnt_q[3:0];
				v_wdata = mem_rdata;
				cnt_d   = cnt_q + 12'd1;
				if (cnt_q[3:0] == x) begin
					state_d = c8cpu_pkg::S_TICK;
				end else begin
					state_d = c8cpu_pkg::S_LOAD_RD;
				end
			end
			c8cpu_pkg::S_TICK: begin
				pc_d = next_q;
				if (dt_q != 8'd0) begin
					dt_d = dt_q - 8'd1;
				end
				if (snd_q != 8'd0) begin
					snd_d = snd_q - 8'd1;
				end
				fin        = 1'b1;
				fin_draw   = draw_q;
				fin_beep   = (snd_q != 8'd0);
				fin_status = unk_q ? c8cpu_pkg::STAT_UNKNOWN : c8cpu_pkg::STAT_OK;
				fin_pc     = next_q;
				state_d    = c8cpu_pkg::S_IDLE;
			end
			default: begin
				state_d = c8cpu_pkg::S_IDLE;
			end
		endcase
	end

	assign busy            = (state_q != c8cpu_pkg::S_IDLE);
	assign done            = done_q;
	assign draw_flag       = out_draw_q;
	assign beep_flag       = out_beep_q;
	assign pixel_on        = out_pix_q;
	assign status          = out_status_q;
	assign program_counter = out_pc_q;

	// an accepted transaction is either finished next cycle or keeps the core busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither busy nor done");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack depth past limit");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt cleared");

	a_halt_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && halt_q) |-> (status == hcode_q))
		else $error("halted core reported wrong status");

endmodule
`default_nettype wire

/* test/tb_chip8_cpu_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for chip8_cpu_core: a behavioral CHIP-8 interpreter predicts every
// transaction result, and the monitor compares it against the done strobe output.
// Depends on c8cpu_pkg and the chip8_cpu_core RTL.
module tb_chip8_cpu_core;
	import c8cpu_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [11:0] ofs;
		logic [7:0]  byt;
		logic [3:0]  keyn;
		logic        keyd;
		logic [7:0]  rnd;
		logic [10:0] pix;
	} cmd_t;

	typedef struct {
		logic        draw;
		logic        beep;
		logic        pix;
		status_t     st;
		logic [11:0] pc;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = '0;
	logic [11:0] load_offset = '0;
	logic [7:0] load_byte = '0;
	logic [3:0] key_number = '0;
	logic key_down = 1'b0;
	logic [7:0] random_byte = '0;
	logic [10:0] pixel_address = '0;
	logic done, draw_flag, beep_flag, pixel_on;
	logic [1:0] status;
	logic [11:0] program_counter;

	chip8_cpu_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.load_offset(load_offset), .load_byte(load_byte), .key_number(key_number),
		.key_down(key_down), .random_byte(random_byte), .pixel_address(pixel_address),
		.done(done), .draw_flag(draw_flag), .beep_flag(beep_flag), .pixel_on(pixel_on),
		.status(status), .program_counter(program_counter)
	);

	always #5 clk = ~clk;

	// interpreter state
	logic [7:0]  ram [4096];
	logic        screen [2048];
	logic [7:0]  vreg [16];
	logic [15:0] ireg;
	logic [11:0] pc_now;
	logic [11:0] calls [16];
	int          depth;
	logic [7:0]  delay_t, sound_t;
	logic        keys [16];
	logic        loaded, halted;
	status_t     halt_st;

	cmd_t     pend_cmds [$];
	outcome_t want_q [$];
	cmd_t     cur;
	int       gap_left = 0;
	bit       quiet = 0;
	int       errors = 0;
	int       pushed = 0;

	function automatic outcome_t chip_predict(cmd_t c);
		outcome_t o;
		logic [15:0] op;
		logic [3:0] x, y, n;
		logic [7:0] nn, a, b;
		logic [11:0] nnn, nxt;
		logic [8:0] sum;
		logic [16:0] s17;
		logic abort;
		int idx, fk;
		o.draw = 0; o.beep = 0; o.pix = 0;
		o.st = halted ? halt_st : STAT_OK;
		case (c.kind)
			KIND_LOAD: begin
				ram[PROG_START + c.ofs] = c.byt;
				loaded = 1;
			end
			KIND_KEY: keys[c.keyn] = c.keyd;
			KIND_PIXEL: o.pix = screen[c.pix];
			KIND_EXEC: if (loaded && !halted) begin
				op = {ram[pc_now], ram[pc_now + 12'd1]};
				x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
				nxt = pc_now + 12'd2;
				abort = 0;
				o.st = STAT_OK;
				case (group_t'(op[15:12]))
					GRP_SYS: begin
						if (op == OP_CLS) begin
							for (int k = 0; k < 2048; k++) screen[k] = 0;
							o.draw = 1;
						end else if (op == OP_RET) begin
							if (depth == 0) begin
								halted = 1; halt_st = STAT_UNDERFLOW;
								o.st = STAT_UNDERFLOW; abort = 1;
							end else begin
								depth--;
								nxt = calls[depth] + 12'd2;
							end
						end else o.st = STAT_UNKNOWN;
					end
					GRP_JP: nxt = nnn;
					GRP_CALL: begin
						if (depth >= 16) begin
							halted = 1; halt_st = STAT_OVERFLOW;
							o.st = STAT_OVERFLOW; abort = 1;
						end else begin
							calls[depth] = pc_now;
							depth++;
							nxt = nnn;
						end
					end
					GRP_SE_IMM: if (vreg[x] == nn) nxt += 12'd2;
					GRP_SNE_IMM: if (vreg[x] != nn) nxt += 12'd2;
					GRP_SE_REG: if (vreg[x] == vreg[y]) nxt += 12'd2;
					GRP_LD_IMM: vreg[x] = nn;
					GRP_ADD_IMM: vreg[x] = vreg[x] + nn;
					GRP_ALU: begin
						a = vreg[x]; b = vreg[y];
						case (n)
							N_MOV: vreg[x] = b;
							N_OR:  vreg[x] = a | b;
							N_AND: vreg[x] = a & b;
							N_XOR: vreg[x] = a ^ b;
							N_ADD: begin
								sum = {1'b0, a} + {1'b0, b};
								vreg[x] = sum[7:0]; vreg[15] = {7'd0, sum[8]};
							end
							N_SUB: begin vreg[x] = a - b; vreg[15] = {7'd0, a > b}; end
							N_SUBN: begin vreg[x] = b - a; vreg[15] = {7'd0, b > a}; end
							N_SHR: begin vreg[x] = a >> 1; vreg[15] = {7'd0, a[0]}; end
							N_SHL: begin vreg[x] = a << 1; vreg[15] = {7'd0, a[7]}; end
							default: o.st = STAT_UNKNOWN;
						endcase
					end
					GRP_SNE_REG: if (vreg[x] != vreg[y]) nxt += 12'd2;
					GRP_LD_I: ireg = {4'd0, nnn};
					GRP_JP_V0: nxt = nnn + {4'd0, vreg[0]};
					GRP_RND: vreg[x] = c.rnd & nn;
					GRP_DRW: begin
						a = vreg[x] & 8'h3F; b = vreg[y] & 8'h1F;
						vreg[15] = 0;
						for (int r = 0; r < n; r++) begin
							logic [11:0] ra;
							logic [7:0] bits;
							ra = ireg[11:0] + r[11:0];
							bits = ram[ra];
							for (int i = 0; i < 8; i++) begin
								idx = a + i + (b + r) * 64;
								if (bits[7 - i] && idx < 2048) begin
									if (screen[idx]) vreg[15] = 1;
									screen[idx] = ~screen[idx];
								end
							end
						end
						o.draw = 1;
					end
					GRP_SKP: begin
						if (nn == EX_SKP) begin
							if (keys[vreg[x][3:0]]) nxt += 12'd2;
						end else if (nn == EX_SKNP) begin
							if (!keys[vreg[x][3:0]]) nxt += 12'd2;
						end else o.st = STAT_UNKNOWN;
					end
					default: begin
						case (nn)
							FX_GET_DELAY: vreg[x] = delay_t;
							FX_SET_DELAY: delay_t = vreg[x];
							FX_SET_SOUND: sound_t = vreg[x];
							FX_ADD_I: begin
								s17 = {1'b0, ireg} + {9'd0, vreg[x]};
								if (s17 > 17'hFFF) vreg[15] = 1;
								ireg = s17[15:0];
							end
							FX_WAIT_KEY: begin
								fk = -1;
								for (int i = 15; i >= 0; i--) if (keys[i]) fk = i;
								if (fk >= 0) vreg[x] = fk[7:0]; else nxt = pc_now;
							end
							FX_FONT: ireg = {8'd0, FONT_START[7:0]} + vreg[x] * 16'd5;
							FX_BCD: begin
								ram[ireg[11:0] + 12'd2] = vreg[x] % 8'd10;
								ram[ireg[11:0] + 12'd1] = (vreg[x] / 8'd10) % 8'd10;
								ram[ireg[11:0]] = vreg[x] / 8'd100;
							end
							FX_STORE: for (int i = 0; i <= x; i++)
								ram[ireg[11:0] + i[11:0]] = vreg[i];
							FX_LOAD: for (int i = 0; i <= x; i++)
								vreg[i] = ram[ireg[11:0] + i[11:0]];
							default: o.st = STAT_UNKNOWN;
						endcase
					end
				endcase
				if (!abort) begin
					pc_now = nxt;
					if (delay_t != 0) delay_t--;
					o.beep = sound_t != 0;
					if (sound_t != 0) sound_t--;
				end
			end
		endcase
		o.pc = pc_now;
		return o;
	endfunction

	// driver: one transaction at a time, random gaps unless quiet
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) want_q.push_back(chip_predict(cur));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					start <= 1'b0;
				end else if (pend_cmds.size() > 0) begin
					cur = pend_cmds.pop_front();
					kind <= cur.kind;
					load_offset <= cur.ofs;
					load_byte <= cur.byt;
					key_number <= cur.keyn;
					key_down <= cur.keyd;
					random_byte <= cur.rnd;
					pixel_address <= cur.pix;
					start <= 1'b1;
					if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (want_q.size() == 0) begin
				$display("%0t: result with no transaction outstanding", $time);
				errors++;
			end else begin
				outcome_t w;
				w = want_q.pop_front();
				if (draw_flag !== w.draw) begin
					$display("%0t: draw_flag exp %0d got %0d", $time, w.draw, draw_flag);
					errors++;
				end
				if (beep_flag !== w.beep) begin
					$display("%0t: beep_flag exp %0d got %0d", $time, w.beep, beep_flag);
					errors++;
				end
				if (pixel_on !== w.pix) begin
					$display("%0t: pixel_on exp %0d got %0d", $time, w.pix, pixel_on);
					errors++;
				end
				if (status !== w.st) begin
					$display("%0t: status exp %0d got %0d", $time, w.st, status);
					errors++;
				end
				if (program_counter !== w.pc) begin
					$display("%0t: program_counter exp %h got %h", $time, w.pc, program_counter);
					errors++;
				end
			end
		end
	end

	function automatic cmd_t noise_cmd(kind_t k);
		cmd_t c;
		c.kind = k;
		c.ofs = 12'($urandom_range(12'h600, 12'hDFF));
		c.byt = 8'($urandom);
		c.keyn = 4'($urandom);
		c.keyd = 1'($urandom);
		c.rnd = 8'($urandom);
		c.pix = 11'($urandom);
		return c;
	endfunction

	task automatic push_cmd(cmd_t c);
		pend_cmds.push_back(c);
		pushed++;
	endtask

	task automatic push_load(logic [11:0] addr, logic [7:0] v);
		cmd_t c;
		c = noise_cmd(KIND_LOAD);
		c.ofs = addr - PROG_START;
		c.byt = v;
		push_cmd(c);
	endtask

	task automatic push_word(logic [11:0] addr, logic [15:0] w);
		push_load(addr, w[15:8]);
		push_load(addr + 12'd1, w[7:0]);
	endtask

	// execute cycles, with key changes, pixel reads and data-region loads mixed in
	task automatic push_run(int cycles);
		int r;
		for (int k = 0; k < cycles; k++) begin
			r = $urandom_range(0, 9);
			if (r == 0) push_cmd(noise_cmd(KIND_KEY));
			else if (r == 1) push_cmd(noise_cmd(KIND_PIXEL));
			else if (r == 2) push_cmd(noise_cmd(KIND_LOAD));
			push_cmd(noise_cmd(KIND_EXEC));
		end
	endtask

	// all queued transactions done, so the interpreter state is current
	task automatic wait_drained();
		while (pend_cmds.size() != 0 || start || want_q.size() != 0) @(negedge clk);
	endtask

	// random opcode; flow-control ones only where jump targets are known
	function automatic logic [15:0] rand_op(bit main, logic [11:0] base, int len);
		logic [3:0] x, y, g;
		logic [15:0] op;
		x = 4'($urandom); y = 4'($urandom);
		g = 4'($urandom);
		case (g)
			4'h0: begin
				if ($urandom_range(0, 1)) op = OP_CLS;
				else op = {4'h0, 4'h1 + 4'($urandom_range(0, 13)), 8'($urandom)};
			end
			4'h1, 4'h2: begin
				if (main) begin
					if (g == 4'h1) op = {4'h1, base + 12'(2 * $urandom_range(0, len - 1))};
					else op = {4'h2, base + 12'(2 * (len + 2))};
				end else op = {4'h6, x, 8'($urandom)};
			end
			4'hA: op = {4'hA, 12'($urandom_range(12'hA00, 12'hEFF))};
			4'hB: op = {4'h7, x, 8'($urandom)};
			4'h8: op = {4'h8, x, y, 4'($urandom)};
			4'hE: begin
				case ($urandom_range(0, 2))
					0: op = {4'hE, x, EX_SKP};
					1: op = {4'hE, x, EX_SKNP};
					default: op = {4'hE, x, 8'($urandom)};
				endcase
			end
			4'hF: begin
				case ($urandom_range(0, 9))
					0: op = {4'hF, x, FX_GET_DELAY};
					1: op = {4'hF, x, FX_WAIT_KEY};
					2: op = {4'hF, x, FX_SET_DELAY};
					3: op = {4'hF, x, FX_SET_SOUND};
					4: op = {4'hF, x, FX_ADD_I};
					5: op = {4'hF, x, FX_FONT};
					6: op = {4'hF, x, FX_BCD};
					7: op = {4'hF, x, FX_STORE};
					8: op = {4'hF, x, FX_LOAD};
					default: op = {4'hF, x, 8'($urandom)};
				endcase
			end
			default: op = {g, x, y, 4'($urandom)};
		endcase
		return op;
	endfunction

	// main block, two closing jumps (so a skip cannot fall through), then a subroutine
	task automatic push_program();
		logic [11:0] base;
		int len, sub;
		base = pc_now;
		len = $urandom_range(6, 14);
		sub = $urandom_range(2, 5);
		for (int k = 0; k < len; k++)
			push_word(base + 12'(2 * k), rand_op(1, base, len));
		push_word(base + 12'(2 * len), {4'h1, base});
		push_word(base + 12'(2 * len + 2), {4'h1, base});
		for (int k = 0; k < sub; k++)
			push_word(base + 12'(2 * (len + 2 + k)), rand_op(0, base, len));
		push_word(base + 12'(2 * (len + 2 + sub)), OP_RET);
		push_word(base + 12'(2 * (len + 3 + sub)), OP_RET);
		push_run($urandom_range(20, 60));
	endtask

	localparam logic [15:0] DIRECTED_OPS [36] = '{
		16'h60FF, 16'h61FF, 16'h8014, 16'h8115, 16'h6205, 16'h6307, 16'h8237, 16'h8326,
		16'h84FE, 16'h8011, 16'h8012, 16'h8013, 16'h8010, 16'h800F, 16'h6A3F, 16'h6B1F,
		16'hA050, 16'hDABF, 16'hDAB5, 16'h00E0, 16'hAFFF, 16'h62FF, 16'hF21E, 16'hF233,
		16'hF355, 16'hF365, 16'hF218, 16'hF215, 16'hF307, 16'hE1A1, 16'hF00A, 16'hC3AA,
		16'h6004, 16'hB240, 16'h0123, 16'hE100
	};

	initial begin
		cmd_t c;
		for (int k = 0; k < 4096; k++) ram[k] = 8'h00;
		for (int k = 0; k < 80; k++) ram[FONT_START + k] = FONT_GLYPHS[k];
		for (int k = 0; k < 2048; k++) screen[k] = 0;
		for (int k = 0; k < 16; k++) begin
			vreg[k] = 0; keys[k] = 0; calls[k] = 0;
		end
		ireg = 0; pc_now = PROG_START; depth = 0; delay_t = 0; sound_t = 0;
		loaded = 0; halted = 0; halt_st = STAT_OK;

		// no program yet: execute must do nothing
		push_cmd(noise_cmd(KIND_EXEC));
		push_cmd(noise_cmd(KIND_EXEC));
		c = noise_cmd(KIND_PIXEL); c.pix = 11'd0; push_cmd(c);
		c = noise_cmd(KIND_PIXEL); c.pix = 11'h7FF; push_cmd(c);
		c = noise_cmd(KIND_KEY); c.keyn = 4'hF; c.keyd = 1; push_cmd(c);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed program: ALU flags, edge sprites, I wrap, BCD, timers, keys, Bnnn
		for (int k = 0; k < 36; k++) push_word(PROG_START + 12'(2 * k), DIRECTED_OPS[k]);
		push_word(12'h248, 16'h1248);
		for (int k = 0; k < 40; k++) push_cmd(noise_cmd(KIND_EXEC));
		c = noise_cmd(KIND_PIXEL); c.pix = 11'h7FF; push_cmd(c);
		c = noise_cmd(KIND_KEY); c.keyn = 4'hF; c.keyd = 0; push_cmd(c);

		while (pushed < 1000) begin
			wait_drained();
			if (halted) break;
			push_program();
		end

		quiet = 1;
		wait_drained();
		if (!halted) push_program();
		wait_drained();
		// end on a deliberate halt: a return with an empty stack, or runaway recursion
		if (!halted) begin
			if (depth == 0 && $urandom_range(0, 1)) push_word(pc_now, OP_RET);
			else push_word(pc_now, {4'h2, pc_now});
			push_run(24);
		end
		for (int k = 0; k < 8; k++) push_cmd(noise_cmd(kind_t'($urandom_range(0, 3))));

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0) $display("tb_chip8_cpu_core passed");
		else $display("tb_chip8_cpu_core failed");
		$finish;
	end

	initial begin
		#8ms;
		$display("tb_chip8_cpu_core failed");
		$finish;
	end

endmodule
